// File: src/type4_tag_apdu_responder_macros.svh
// Assertion macros for the Type 4 tag APDU responder.
// Needs signals named clock and reset in the module that uses them.
`ifndef TYPE4_TAG_APDU_RESPONDER_MACROS_SVH
`define TYPE4_TAG_APDU_RESPONDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define T4T_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define T4T_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/t4t_pkg.sv
// Shared types, constants and lookup functions of the Type 4 tag responder.
// No dependencies; used by t4t_datapath, t4t_ctrl and the top level.
`default_nettype none

package t4t_pkg;

   localparam int NDEF_BYTES = 4096;
   localparam int NDEF_AW    = $clog2(NDEF_BYTES);
   localparam int OFF_W      = 17;
   localparam int POS_W      = 9;
   localparam int LIM_W      = 7;
   localparam int LEN_W      = 6;

   localparam logic [POS_W-1:0] POS_MAX  = '1;
   localparam logic [POS_W-1:0] HDR_LEN  = 9'd5;
   localparam logic [LIM_W-1:0] RESP_CAP = 7'd64;
   localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd49;
   localparam logic [OFF_W-1:0] CC_BYTES = 17'd15;

   localparam logic [7:0] CLA_ISO     = 8'h00;
   localparam logic [7:0] CLA_RATS    = 8'hE0;
   localparam logic [7:0] INS_SELECT  = 8'hA4;
   localparam logic [7:0] INS_READ    = 8'hB0;
   localparam logic [7:0] INS_UPDATE  = 8'hD6;
   localparam logic [7:0] P1_BY_ID    = 8'h00;
   localparam logic [7:0] P1_BY_NAME  = 8'h04;
   localparam logic [7:0] P2_ID_MASK  = 8'h0C;
   localparam logic [7:0] LC_ID       = 8'd2;
   localparam logic [7:0] LC_NAME     = 8'd7;

   localparam logic [7:0] SW1_OK      = 8'h90;
   localparam logic [7:0] SW2_OK      = 8'h00;
   localparam logic [7:0] SW1_FAIL    = 8'h6A;
   localparam logic [7:0] SW2_NOFILE  = 8'h82;
   localparam logic [7:0] SW2_BADID   = 8'h00;

   localparam logic [1:0] FILE_NONE = 2'd0;
   localparam logic [1:0] FILE_CC   = 2'd1;
   localparam logic [1:0] FILE_NDEF = 2'd2;

   typedef enum logic [1:0] {
      OC_BYTE        = 2'd0,
      OC_SILENT      = 2'd1,
      OC_UNSUPPORTED = 2'd2,
      OC_NO_SPACE    = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      RES_FLAG   = 2'd0,
      RES_STATUS = 2'd1,
      RES_READ   = 2'd2
   } res_kind_type;

   typedef enum logic [1:0] {
      OUT_FLAG = 2'd0,
      OUT_DATA = 2'd1,
      OUT_SW1  = 2'd2,
      OUT_SW2  = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic        clear_step;
      logic        accept;
      logic        decide;
      logic        load;
      out_sel_type out_sel;
      logic        rd_advance;
   } dp_cmd_type;

   typedef struct packed {
      logic         clear_done;
      res_kind_type kind;
      logic         rd_done;
   } dp_sts_type;

   function automatic logic [7:0] cc_byte(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0:    v = 8'h00;
         4'd1:    v = 8'h0F;
         4'd2:    v = 8'h10;
         4'd3:    v = 8'h00;
         4'd4:    v = 8'h2F;
         4'd5:    v = 8'h00;
         4'd6:    v = 8'h2F;
         4'd7:    v = 8'h04;
         4'd8:    v = 8'h06;
         4'd9:    v = 8'hE1;
         4'd10:   v = 8'h04;
         4'd11:   v = 8'hFF;
         4'd12:   v = 8'hFE;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] id_cc_byte(input logic idx);
      return idx ? 8'h03 : 8'hE1;
   endfunction

   function automatic logic [7:0] id_ndef_byte(input logic idx);
      return idx ? 8'h04 : 8'hE1;
   endfunction

   function automatic logic [7:0] app_name_byte(input logic [2:0] idx);
      logic [7:0] v;
      case (idx)
         3'd0:    v = 8'hD2;
         3'd1:    v = 8'h76;
         3'd2:    v = 8'h00;
         3'd3:    v = 8'h00;
         3'd4:    v = 8'h85;
         3'd5:    v = 8'h01;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: src/t4t_datapath.sv
// Datapath: command header capture, match flags, NDEF store, decode and
// response word register. Depends on t4t_pkg.
`default_nettype none

module t4t_datapath import t4t_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [LIM_W-1:0]        csr_response_limit,
   input  logic [7:0]              cmd_byte,
   input  dp_cmd_type              cmd,
   output dp_sts_type              sts,
   output logic [7:0]              resp_byte,
   output logic                    resp_last,
   output logic [1:0]              outcome
);

   logic [LIM_W-1:0]   limit_ff, limit_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         hdr_ff [5];
   logic [7:0]         hdr_in [5];
   logic [1:0]         sel_ff, sel_in;
   logic [2:0]         mf_ff, mf_in;
   logic [NDEF_AW-1:0] clr_addr_ff, clr_addr_in;

   outcome_type        res_oc_ff;
   logic [7:0]         sw1_ff, sw2_ff;
   logic [LEN_W-1:0]   rd_len_ff, rd_cnt_ff;
   logic [OFF_W-1:0]   rd_addr_ff;
   logic [7:0]         rd_data_ff;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   outcome_type        oc_ff, oc_in;

   logic [7:0]         store_ff [NDEF_BYTES];

   logic               in_hdr;
   logic [POS_W-1:0]   data_idx;
   logic [OFF_W-1:0]   wr_addr;
   logic               wr_en;
   logic               mem_we;
   logic [NDEF_AW-1:0] mem_waddr;
   logic [7:0]         mem_wdata;

   res_kind_type       dec_kind;
   outcome_type        dec_oc;
   logic [7:0]         dec_sw1, dec_sw2;
   logic               dec_sel_we;
   logic [1:0]         dec_sel;
   logic [LIM_W-1:0]   eff_lim;
   logic [7:0]         rd_val;

   assign in_hdr   = pos_ff < HDR_LEN;
   assign data_idx = pos_ff - HDR_LEN;
   assign wr_addr  = {1'b0, hdr_ff[2], hdr_ff[3]} + {{(OFF_W-POS_W){1'b0}}, data_idx};
   assign wr_en    = cmd.accept && !in_hdr && hdr_ff[0] == CLA_ISO && hdr_ff[1] == INS_UPDATE
                     && data_idx < {1'b0, hdr_ff[4]} && wr_addr < OFF_W'(NDEF_BYTES);

   // Per-byte capture and per-command clear
   always_comb begin
      limit_in    = csr_valid ? csr_response_limit : limit_ff;
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      mf_in       = mf_ff;
      sel_in      = sel_ff;
      clr_addr_in = cmd.clear_step ? clr_addr_ff + 1'b1 : clr_addr_ff;
      if (cmd.accept) begin
         if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;
         if (in_hdr) begin
            hdr_in[pos_ff[2:0]] = cmd_byte;
         end else begin
            if (data_idx < 9'd2) begin
               if (cmd_byte != id_cc_byte(data_idx[0]))   mf_in[0] = 1'b0;
               if (cmd_byte != id_ndef_byte(data_idx[0])) mf_in[1] = 1'b0;
            end
            if (data_idx < 9'd7 && cmd_byte != app_name_byte(data_idx[2:0])) mf_in[2] = 1'b0;
         end
      end
      if (cmd.decide) begin
         pos_in = '0;
         for (int k = 0; k < 5; k++) hdr_in[k] = '0;
         mf_in = 3'b111;
         if (dec_sel_we) sel_in = dec_sel;
      end
   end

   // Command decode from the captured header
   always_comb begin
      dec_kind   = RES_FLAG;
      dec_oc     = OC_UNSUPPORTED;
      dec_sw1    = SW1_OK;
      dec_sw2    = SW2_OK;
      dec_sel_we = 1'b0;
      dec_sel    = FILE_NONE;
      eff_lim    = (limit_ff > RESP_CAP) ? RESP_CAP : limit_ff;
      if (pos_ff == 9'd2 && hdr_ff[0] == CLA_RATS) begin
         dec_oc = OC_SILENT;
      end else if (pos_ff < 9'd4 || hdr_ff[0] != CLA_ISO) begin
         dec_oc = OC_UNSUPPORTED;
      end else if (hdr_ff[1] == INS_SELECT) begin
         if (hdr_ff[2] == P1_BY_ID) begin
            if ((hdr_ff[3] | P2_ID_MASK) == P2_ID_MASK) begin
               dec_kind   = RES_STATUS;
               dec_sel_we = 1'b1;
               if (hdr_ff[4] == LC_ID && pos_ff >= 9'd7 && mf_ff[0]) begin
                  dec_sel = FILE_CC;
               end else if (hdr_ff[4] == LC_ID && pos_ff >= 9'd7 && mf_ff[1]) begin
                  dec_sel = FILE_NDEF;
               end else begin
                  dec_sel = FILE_NONE;
                  dec_sw1 = SW1_FAIL;
                  dec_sw2 = SW2_BADID;
               end
            end
         end else if (hdr_ff[2] == P1_BY_NAME) begin
            if (hdr_ff[3] == 8'h00) begin
               dec_kind = RES_STATUS;
               if (!(hdr_ff[4] == LC_NAME && pos_ff >= 9'd12 && mf_ff[2])) begin
                  dec_sw1 = SW1_FAIL;
                  dec_sw2 = SW2_NOFILE;
               end
            end
         end
      end else if (hdr_ff[1] == INS_READ) begin
         if (({1'b0, hdr_ff[4]} + 9'd2) > {2'b00, eff_lim}) begin
            dec_oc = OC_NO_SPACE;
         end else if (sel_ff inside {FILE_CC, FILE_NDEF}) begin
            dec_kind = RES_READ;
         end else begin
            dec_kind = RES_STATUS;
            dec_sw1  = SW1_FAIL;
            dec_sw2  = SW2_NOFILE;
         end
      end else if (hdr_ff[1] == INS_UPDATE) begin
         dec_kind = RES_STATUS;
      end
   end

   // Read byte: past the end of a file reads as zero
   always_comb begin
      if (sel_ff == FILE_CC) begin
         rd_val = (rd_addr_ff < CC_BYTES) ? cc_byte(rd_addr_ff[3:0]) : 8'h00;
      end else begin
         rd_val = (rd_addr_ff < OFF_W'(NDEF_BYTES)) ? rd_data_ff : 8'h00;
      end
   end

   // Response word select
   always_comb begin
      byte_in = byte_ff;
      last_in = last_ff;
      oc_in   = oc_ff;
      if (cmd.load) begin
         case (cmd.out_sel)
            OUT_DATA: begin
               byte_in = rd_val;
               last_in = 1'b0;
               oc_in   = OC_BYTE;
            end
            OUT_SW1: begin
               byte_in = sw1_ff;
               last_in = 1'b0;
               oc_in   = OC_BYTE;
            end
            OUT_SW2: begin
               byte_in = sw2_ff;
               last_in = 1'b1;
               oc_in   = OC_BYTE;
            end
            default: begin
               byte_in = 8'h00;
               last_in = 1'b1;
               oc_in   = res_oc_ff;
            end
         endcase
      end
   end

   assign mem_we    = cmd.clear_step | wr_en;
   assign mem_waddr = cmd.clear_step ? clr_addr_ff : wr_addr[NDEF_AW-1:0];
   assign mem_wdata = cmd.clear_step ? 8'h00 : cmd_byte;

   always_ff @(posedge clock) begin
      if (mem_we) store_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= store_ff[rd_addr_ff[NDEF_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         pos_ff      <= '0;
         for (int k = 0; k < 5; k++) hdr_ff[k] <= '0;
         sel_ff      <= FILE_NONE;
         mf_ff       <= 3'b111;
         clr_addr_ff <= '0;
      end else begin
         limit_ff    <= limit_in;
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         sel_ff      <= sel_in;
         mf_ff       <= mf_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         res_oc_ff  <= dec_oc;
         sw1_ff     <= dec_sw1;
         sw2_ff     <= dec_sw2;
         rd_len_ff  <= hdr_ff[4][LEN_W-1:0];
         rd_cnt_ff  <= '0;
         rd_addr_ff <= {1'b0, hdr_ff[2], hdr_ff[3]};
      end else if (cmd.rd_advance) begin
         rd_cnt_ff  <= rd_cnt_ff + 1'b1;
         rd_addr_ff <= rd_addr_ff + 1'b1;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      oc_ff   <= oc_in;
   end

   assign sts.clear_done = clr_addr_ff == NDEF_AW'(NDEF_BYTES - 1);
   assign sts.kind       = dec_kind;
   assign sts.rd_done    = rd_cnt_ff == rd_len_ff;

   assign resp_byte = byte_ff;
   assign resp_last = last_ff;
   assign outcome   = oc_ff;

endmodule

`default_nettype wire

// File: src/t4t_ctrl.sv
// Controller state machine of the Type 4 tag responder: clear pass, byte
// intake, command decode and response sequencing. Depends on t4t_pkg.
`default_nettype none
`include "type4_tag_apdu_responder_macros.svh"

module t4t_ctrl import t4t_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_cmd_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_RECV    = 8'b0000_0010,
      ST_DECIDE  = 8'b0000_0100,
      ST_FLAG    = 8'b0000_1000,
      ST_RD_ADDR = 8'b0001_0000,
      ST_RD_DATA = 8'b0010_0000,
      ST_SW1     = 8'b0100_0000,
      ST_SW2     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_RECV;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = OUT_FLAG;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_RECV;
         end
         ST_RECV: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_cmd_last) state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            case (sts.kind)
               RES_READ:   state_in = ST_RD_ADDR;
               RES_STATUS: state_in = ST_SW1;
               default:    state_in = ST_FLAG;
            endcase
         end
         ST_FLAG: begin
            if (out_free) begin
               cmd.load    = 1'b1;
               cmd.out_sel = OUT_FLAG;
               state_in    = ST_RECV;
            end
         end
         ST_RD_ADDR: begin
            // store read data lands in the cycle after the address settles
            state_in = sts.rd_done ? ST_SW1 : ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (out_free) begin
               cmd.load       = 1'b1;
               cmd.out_sel    = OUT_DATA;
               cmd.rd_advance = 1'b1;
               state_in       = ST_RD_ADDR;
            end
         end
         ST_SW1: begin
            if (out_free) begin
               cmd.load    = 1'b1;
               cmd.out_sel = OUT_SW1;
               state_in    = ST_SW2;
            end
         end
         ST_SW2: begin
            if (out_free) begin
               cmd.load    = 1'b1;
               cmd.out_sel = OUT_SW2;
               state_in    = ST_RECV;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `T4T_ASSERT_NEXT(a_last_word_decodes, req_valid && req_ready && req_cmd_last, state_ff == ST_DECIDE, "final command word not followed by decode")
   `T4T_ASSERT_NOW(a_load_into_free_reg, cmd.load, !rsp_valid_ff || rsp_ready, "response word overwritten before taken")
   `T4T_ASSERT_NEXT(a_decode_single_cycle, state_ff == ST_DECIDE, state_ff != ST_DECIDE && state_ff != ST_RECV, "decode did not advance to a response")

endmodule

`default_nettype wire

// File: src/type4_tag_apdu_responder.sv
// Type 4 tag APDU responder: command words in, response words out.
// Intake takes one command word per cycle while req_ready is high; decode follows in the cycle
// after the final word. A flagged outcome or status word leaves one per cycle while rsp_ready
// holds; each read data word waits in turn for the registered read port of the NDEF store.
// Reset: synchronous; the store is swept to zero, one entry per cycle, with req_ready low;
// configuration writes are taken during the sweep.
`default_nettype none

module type4_tag_apdu_responder import t4t_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // command word channel
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_cmd_byte,
   input  logic             req_cmd_last,
   // response word channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_resp_byte,
   output logic             rsp_resp_last,
   output logic [1:0]       rsp_outcome,
   // response limit register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LIM_W-1:0] csr_response_limit
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // The limit register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // Controller: sweeps the store, gathers command words, steps the response
   t4t_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_cmd_last (req_cmd_last),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .sts          (sts)
   );

   // Datapath: header capture, id matching, NDEF store, decode, output word
   t4t_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_response_limit (csr_response_limit),
      .cmd_byte           (req_cmd_byte),
      .cmd                (cmd),
      .sts                (sts),
      .resp_byte          (rsp_resp_byte),
      .resp_last          (rsp_resp_last),
      .outcome            (rsp_outcome)
   );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for the Type 4 tag APDU responder: directed commands, then random traffic.
// Depends on t4t_pkg (codes, widths) and the type4_tag_apdu_responder top level only.
`timescale 1ns / 1ps

module tb import t4t_pkg::*; ();

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      outcome_type oc;
   } resp_word_type;

   // File images and identifiers, packed most significant byte first
   localparam logic [119:0] CC_IMAGE = 120'h000F10002F002F0406E104FFFE0000;
   localparam logic [15:0]  ID_CC    = 16'hE103;
   localparam logic [15:0]  ID_NDEF  = 16'hE104;
   localparam logic [15:0]  ID_WRONG = 16'hE105;
   localparam logic [55:0]  APP_NAME = 56'hD2760000850100;
   localparam logic [7:0]   INS_UNKNOWN = 8'hCA;
   localparam logic [7:0]   P1_BAD      = 8'h02;
   localparam logic [7:0]   RATS_PARAM  = 8'h50;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_cmd_byte = '0;
   logic             req_cmd_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_resp_byte;
   logic             rsp_resp_last;
   logic [1:0]       rsp_outcome;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LIM_W-1:0] csr_response_limit = '0;

   // Shadow of the responder state
   logic [POS_W-1:0] cmd_pos;
   logic [7:0]       hdr [5];
   logic [1:0]       sel_file;
   logic [2:0]       id_match;
   logic [7:0]       ndef_copy [NDEF_BYTES];
   logic [LIM_W-1:0] limit_copy;

   resp_word_type resp_due [$];
   logic [7:0] cmd_buf [$];
   int         words_sent = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         n_errors = 0;

   type4_tag_apdu_responder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd_byte       (req_cmd_byte),
      .req_cmd_last       (req_cmd_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_resp_byte      (rsp_resp_byte),
      .rsp_resp_last      (rsp_resp_last),
      .rsp_outcome        (rsp_outcome),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_response_limit (csr_response_limit)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic logic [LIM_W-1:0] eff_limit();
      return (limit_copy > RESP_CAP) ? RESP_CAP : limit_copy;
   endfunction

   function automatic void push_word(input logic [7:0] d, input logic l, input outcome_type o);
      resp_word_type w;
      w.data = d;
      w.last = l;
      w.oc   = o;
      resp_due.push_back(w);
   endfunction

   function automatic void push_flag(input outcome_type o);
      push_word(8'h00, 1'b1, o);
   endfunction

   function automatic void push_status(input logic [7:0] sw1, input logic [7:0] sw2);
      push_word(sw1, 1'b0, OC_BYTE);
      push_word(sw2, 1'b1, OC_BYTE);
   endfunction

   function automatic void clear_cmd();
      cmd_pos = '0;
      for (int i = 0; i < 5; i++) hdr[i] = 8'h00;
      id_match = 3'b111;
   endfunction

   // Work out the answer to a finished command from the header, the byte count
   // and the id match flags gathered while the data came in.
   function automatic void answer_command();
      int         total, got, lc, off, a, i;
      logic [7:0] cla, ins, p1, p2, v;
      total = int'(cmd_pos);
      cla   = hdr[0];
      ins   = hdr[1];
      p1    = hdr[2];
      p2    = hdr[3];
      lc    = int'(hdr[4]);
      got   = (total > 5) ? total - 5 : 0;
      off   = int'({p1, p2});
      if (total == 2 && cla == CLA_RATS) begin
         push_flag(OC_SILENT);
      end else if (total < 4 || cla != CLA_ISO) begin
         push_flag(OC_UNSUPPORTED);
      end else if (ins == INS_SELECT) begin
         if (p1 == P1_BY_ID) begin
            if ((p2 | P2_ID_MASK) != P2_ID_MASK) begin
               push_flag(OC_UNSUPPORTED);
            end else if (lc == int'(LC_ID) && got >= 2 && id_match[0]) begin
               sel_file = FILE_CC;
               push_status(SW1_OK, SW2_OK);
            end else if (lc == int'(LC_ID) && got >= 2 && id_match[1]) begin
               sel_file = FILE_NDEF;
               push_status(SW1_OK, SW2_OK);
            end else begin
               sel_file = FILE_NONE;
               push_status(SW1_FAIL, SW2_BADID);
            end
         end else if (p1 == P1_BY_NAME) begin
            if (p2 != 8'h00)
               push_flag(OC_UNSUPPORTED);
            else if (lc == int'(LC_NAME) && got >= 7 && id_match[2])
               push_status(SW1_OK, SW2_OK);
            else
               push_status(SW1_FAIL, SW2_NOFILE);
         end else begin
            push_flag(OC_UNSUPPORTED);
         end
      end else if (ins == INS_READ) begin
         // size check wins over the file check
         if (lc + 2 > int'(eff_limit())) begin
            push_flag(OC_NO_SPACE);
         end else if (sel_file != FILE_CC && sel_file != FILE_NDEF) begin
            push_status(SW1_FAIL, SW2_NOFILE);
         end else begin
            for (i = 0; i < lc; i++) begin
               a = off + i;
               v = 8'h00;
               if (sel_file == FILE_CC) begin
                  if (a < 15) v = CC_IMAGE[119 - 8 * a -: 8];
               end else if (a < NDEF_BYTES) begin
                  v = ndef_copy[a];
               end
               push_word(v, 1'b0, OC_BYTE);
            end
            push_status(SW1_OK, SW2_OK);
         end
      end else if (ins == INS_UPDATE) begin
         push_status(SW1_OK, SW2_OK);
      end else begin
         push_flag(OC_UNSUPPORTED);
      end
   endfunction

   // Fold one accepted command word into the shadow state.
   function automatic void take_cmd_byte(input logic [7:0] b, input logic last);
      int di, a;
      if (cmd_pos < HDR_LEN) begin
         hdr[cmd_pos] = b;
      end else begin
         di = int'(cmd_pos) - 5;
         if (di < 2) begin
            if (b != ID_CC[15 - 8 * di -: 8]) id_match[0] = 1'b0;
            if (b != ID_NDEF[15 - 8 * di -: 8]) id_match[1] = 1'b0;
         end
         if (di < 7 && b != APP_NAME[55 - 8 * di -: 8]) id_match[2] = 1'b0;
         // update data lands as it arrives, whatever file is selected
         if (hdr[0] == CLA_ISO && hdr[1] == INS_UPDATE && di < int'(hdr[4])) begin
            a = int'({hdr[2], hdr[3]}) + di;
            if (a < NDEF_BYTES) ndef_copy[a] = b;
         end
      end
      if (cmd_pos != POS_MAX) cmd_pos = cmd_pos + 1'b1;
      if (last) begin
         answer_command();
         clear_cmd();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic log_error(input string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Compare every accepted response word with the oldest one due, then
   // choose whether to stall the next cycle.
   always @(posedge clock) begin : check_resp
      resp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (resp_due.size() == 0) begin
            log_error($sformatf("unexpected word: byte %h last %b outcome %0d",
                                rsp_resp_byte, rsp_resp_last, rsp_outcome));
         end else begin
            want = resp_due.pop_front();
            if (rsp_resp_byte != want.data || rsp_resp_last != want.last ||
                rsp_outcome != want.oc)
               log_error($sformatf(
                  "expected byte %h last %b outcome %0d, got byte %h last %b outcome %0d",
                  want.data, want.last, want.oc, rsp_resp_byte, rsp_resp_last,
                  rsp_outcome));
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // ---------------------------------------------------------------- driving

   // Hold one command word until the responder takes it; drop valid only
   // while idling so it never falls and rises in one step.
   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd_byte <= b;
      req_cmd_last <= last;
      do @(posedge clock); while (!req_ready);
      take_cmd_byte(b, last);
      words_sent++;
   endtask

   task automatic send_cmd();
      foreach (cmd_buf[i]) send_word(cmd_buf[i], i == cmd_buf.size() - 1);
   endtask

   task automatic start_apdu(input logic [7:0] cla, input logic [7:0] ins,
                             input logic [7:0] p1, input logic [7:0] p2, input int lc);
      cmd_buf.delete();
      cmd_buf.push_back(cla);
      cmd_buf.push_back(ins);
      cmd_buf.push_back(p1);
      cmd_buf.push_back(p2);
      cmd_buf.push_back(8'(lc));
   endtask

   task automatic send_read(input logic [7:0] p1, input logic [7:0] p2, input int lc);
      start_apdu(CLA_ISO, INS_READ, p1, p2, lc);
      send_cmd();
   endtask

   task automatic send_select_id(input logic [7:0] p2, input logic [15:0] id);
      start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, p2, LC_ID);
      cmd_buf.push_back(id[15:8]);
      cmd_buf.push_back(id[7:0]);
      send_cmd();
   endtask

   // Pause the sender until every due word has come, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (resp_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIM_W-1:0] v);
      csr_valid          <= 1'b1;
      csr_response_limit <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      limit_copy = v;
   endtask

   // ---------------------------------------------------------------- directed tests

   task automatic test_rats_and_short();
      // RATS: two words starting E0, no answer but the silent flag
      cmd_buf.delete();
      cmd_buf.push_back(CLA_RATS);
      cmd_buf.push_back(RATS_PARAM);
      send_cmd();
      // E0 alone, then with three and four words: short or bad class
      cmd_buf.delete();
      cmd_buf.push_back(CLA_RATS);
      send_cmd();
      cmd_buf.push_back(RATS_PARAM);
      cmd_buf.push_back(8'h00);
      send_cmd();
      cmd_buf.push_back(8'h00);
      send_cmd();
      // three header words only
      cmd_buf.delete();
      cmd_buf.push_back(CLA_ISO);
      cmd_buf.push_back(INS_SELECT);
      cmd_buf.push_back(P1_BY_ID);
      send_cmd();
   endtask

   task automatic test_header_errors();
      int i;
      start_apdu(8'hFF, INS_SELECT, P1_BY_ID, P2_ID_MASK, LC_ID);
      cmd_buf.push_back(ID_CC[15:8]);
      cmd_buf.push_back(ID_CC[7:0]);
      send_cmd();
      start_apdu(CLA_ISO, INS_UNKNOWN, 8'h00, 8'h00, 0);
      send_cmd();
      start_apdu(CLA_ISO, INS_SELECT, P1_BAD, 8'h00, LC_ID);
      cmd_buf.push_back(ID_CC[15:8]);
      cmd_buf.push_back(ID_CC[7:0]);
      send_cmd();
      // P2 outside the four allowed values
      send_select_id(8'h01, ID_CC);
      start_apdu(CLA_ISO, INS_SELECT, P1_BY_NAME, 8'h01, LC_NAME);
      for (i = 0; i < 7; i++) cmd_buf.push_back(APP_NAME[55 - 8 * i -: 8]);
      send_cmd();
   endtask

   task automatic test_select();
      int i;
      start_apdu(CLA_ISO, INS_SELECT, P1_BY_NAME, 8'h00, LC_NAME);
      for (i = 0; i < 7; i++) cmd_buf.push_back(APP_NAME[55 - 8 * i -: 8]);
      send_cmd();
      // same name with its final byte wrong
      cmd_buf[11] = 8'h01;
      send_cmd();
      // nothing selected yet
      send_read(8'h00, 8'h00, 4);
      send_select_id(P2_ID_MASK, ID_CC);
      send_read(8'h00, 8'h00, 15);
      // run past the end of the capability container
      send_read(8'h00, 8'h0A, 10);
      // unknown id clears the selection
      send_select_id(8'h00, ID_WRONG);
      send_read(8'h00, 8'h00, 1);
      // header stops before LC
      cmd_buf.delete();
      cmd_buf.push_back(CLA_ISO);
      cmd_buf.push_back(INS_SELECT);
      cmd_buf.push_back(P1_BY_ID);
      cmd_buf.push_back(8'h04);
      send_cmd();
      // LC of two but a single data word
      start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, 8'h08, LC_ID);
      cmd_buf.push_back(ID_NDEF[15:8]);
      send_cmd();
      // right id behind a wrong LC
      start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, 8'h00, 3);
      cmd_buf.push_back(ID_NDEF[15:8]);
      cmd_buf.push_back(ID_NDEF[7:0]);
      cmd_buf.push_back(8'h00);
      send_cmd();
      send_select_id(8'h04, ID_NDEF);
   endtask

   task automatic test_update_read();
      int i;
      start_apdu(CLA_ISO, INS_UPDATE, 8'h00, 8'h00, 4);
      cmd_buf.push_back(8'hFF);
      cmd_buf.push_back(8'h00);
      cmd_buf.push_back(8'hA5);
      cmd_buf.push_back(8'h5A);
      send_cmd();
      send_read(8'h00, 8'h00, 6);
      // straddle the end of the store: the upper half is dropped
      start_apdu(CLA_ISO, INS_UPDATE, 8'h0F, 8'hFC, 8);
      for (i = 0; i < 8; i++) cmd_buf.push_back(8'($urandom));
      send_cmd();
      send_read(8'h0F, 8'hF8, 16);
      // data past LC is ignored
      start_apdu(CLA_ISO, INS_UPDATE, 8'h00, 8'h10, 3);
      for (i = 0; i < 5; i++) cmd_buf.push_back(8'($urandom));
      send_cmd();
      // fewer data words than LC still answers OK
      start_apdu(CLA_ISO, INS_UPDATE, 8'h00, 8'h20, 6);
      for (i = 0; i < 2; i++) cmd_buf.push_back(8'($urandom));
      send_cmd();
      send_read(8'h00, 8'h10, 24);
      // largest LC, running off the end
      start_apdu(CLA_ISO, INS_UPDATE, 8'h0F, 8'hF0, 255);
      for (i = 0; i < 20; i++) cmd_buf.push_back(8'($urandom));
      send_cmd();
      send_read(8'h0F, 8'hF0, 16);
      send_read(8'hFF, 8'hFF, 4);
      // update goes to the store while the container is selected
      send_select_id(8'h00, ID_CC);
      start_apdu(CLA_ISO, INS_UPDATE, 8'h00, 8'h40, 2);
      cmd_buf.push_back(8'h3C);
      cmd_buf.push_back(8'hC3);
      send_cmd();
      send_select_id(8'h00, ID_NDEF);
      send_read(8'h00, 8'h40, 2);
   endtask

   task automatic test_limits();
      settle();
      write_limit(7'd2);
      send_read(8'h00, 8'h00, 0);
      send_read(8'h00, 8'h00, 1);
      settle();
      write_limit(RESP_CAP);
      send_read(8'h00, 8'h00, 62);
      send_read(8'h00, 8'h00, 63);
      // above the cap acts as the cap
      settle();
      write_limit(7'h7F);
      send_read(8'h00, 8'h00, 62);
      send_read(8'h00, 8'h00, 63);
      // size check comes before the no-file check
      settle();
      write_limit(7'd0);
      send_select_id(8'h00, ID_WRONG);
      send_read(8'h00, 8'h00, 0);
      settle();
      write_limit(LIMIT_RESET);
      send_select_id(8'h00, ID_NDEF);
   endtask

   // ---------------------------------------------------------------- random traffic

   function automatic int pick_offset();
      int r;
      r = $urandom_range(9);
      if (r < 7) return $urandom_range(63);
      if (r < 9) return NDEF_BYTES - $urandom_range(64, 1);
      return $urandom_range(16'hFFFF);
   endfunction

   // Mostly well-formed commands with random content; the rest is noise.
   task automatic random_command();
      int pick, r, lc, nd, off, lim, i;
      pick = $urandom_range(99);
      lim  = int'(eff_limit());
      if (pick < 20) begin
         start_apdu(CLA_ISO, INS_SELECT, P1_BY_ID, 8'($urandom_range(3) << 2), LC_ID);
         cmd_buf.push_back(ID_CC[15:8]);
         cmd_buf.push_back($urandom_range(1) ? ID_CC[7:0] : ID_NDEF[7:0]);
         if ($urandom_range(9) == 0)
            cmd_buf[5 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
         if ($urandom_range(9) == 0) void'(cmd_buf.pop_back());
      end else if (pick < 28) begin
         start_apdu(CLA_ISO, INS_SELECT, P1_BY_NAME, 8'h00, LC_NAME);
         for (i = 0; i < 7; i++) cmd_buf.push_back(APP_NAME[55 - 8 * i -: 8]);
         if ($urandom_range(4) == 0)
            cmd_buf[5 + $urandom_range(6)] ^= 8'(1 << $urandom_range(7));
         if ($urandom_range(7) == 0) void'(cmd_buf.pop_back());
      end else if (pick < 55) begin
         off = pick_offset();
         if (lim >= 2 && $urandom_range(7) != 0) lc = $urandom_range(lim - 2);
         else lc = $urandom_range(255);
         start_apdu(CLA_ISO, INS_READ, 8'(off >> 8), 8'(off), lc);
      end else if (pick < 78) begin
         off = pick_offset();
         lc  = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(12, 1);
         r   = $urandom_range(7);
         nd  = (r == 0) ? $urandom_range(lc) : (r == 1) ? lc + $urandom_range(4, 1) : lc;
         start_apdu(CLA_ISO, INS_UPDATE, 8'(off >> 8), 8'(off), lc);
         for (i = 0; i < nd; i++) cmd_buf.push_back(8'($urandom));
      end else begin
         r = $urandom_range(5);
         cmd_buf.delete();
         case (r)
            0: begin
               cmd_buf.push_back(CLA_RATS);
               cmd_buf.push_back(8'($urandom));
            end
            1: begin
               nd = $urandom_range(9, 1);
               for (i = 0; i < nd; i++) cmd_buf.push_back(8'($urandom));
            end
            2: begin
               start_apdu(CLA_ISO, 8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(255));
               nd = $urandom_range(1);
               for (i = 0; i < nd; i++) void'(cmd_buf.pop_back());
            end
            3: begin
               start_apdu(CLA_ISO, INS_SELECT, 8'($urandom_range(7)), 8'($urandom),
                          $urandom_range(9));
               nd = $urandom_range(3);
               for (i = 0; i < nd; i++) cmd_buf.push_back(8'($urandom));
            end
            4: begin
               start_apdu(8'($urandom_range(255, 1)), INS_READ, 8'h00, 8'h00, 2);
            end
            default: begin
               nd = $urandom_range(3, 1);
               cmd_buf.push_back(CLA_ISO);
               for (i = 1; i < nd; i++) cmd_buf.push_back(8'($urandom));
            end
         endcase
      end
      send_cmd();
   endtask

   task automatic test_random_phase(input int send_idle, input int rsp_stall,
                                    input logic [LIM_W-1:0] lim, input int n_words);
      int stop_at;
      settle();
      idle_pct  = send_idle;
      stall_pct = rsp_stall;
      write_limit(lim);
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) random_command();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      limit_copy = LIMIT_RESET;
      sel_file   = FILE_NONE;
      clear_cmd();
      for (int a = 0; a < NDEF_BYTES; a++) ndef_copy[a] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // taken while the store is still being swept
      write_limit(LIMIT_RESET);
      test_rats_and_short();
      test_header_errors();
      test_select();
      test_update_read();
      test_limits();
      test_random_phase(0, 0, RESP_CAP, 38);
      test_random_phase(61, 0, LIM_W'($urandom_range(64, 2)), 38);
      test_random_phase(0, 61, 7'h7F, 38);
      test_random_phase(10, 10, LIM_W'($urandom_range(64, 2)), 38);
      settle();
      if (n_errors == 0 && resp_due.size() == 0) begin
         $display("type4_tag_apdu_responder regression: pass");
      end else begin
         $display("type4_tag_apdu_responder regression: fail");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #1000000;
      $display("type4_tag_apdu_responder regression: fail");
      $finish;
   end

endmodule

// File: type4_tag_apdu_responder.f
+incdir+src
src/t4t_pkg.sv
src/t4t_datapath.sv
src/t4t_ctrl.sv
src/type4_tag_apdu_responder.sv
sim/tb.sv
